FILE: hdl/cfs_pkg.sv
// cfs_pkg: shared types and constants for the csv field splitter
// used by the csv_field_splitter top level
`timescale 1ns / 1ps

package cfs_pkg;

   localparam int          FIELD_COUNT_MAX_DEF = 255;
   localparam longint      LINE_COUNT_MAX_DEF  = 65535;

   localparam logic [7:0]  BYTE_NUL = 8'd0;
   localparam logic [7:0]  BYTE_LF  = 8'd10;
   localparam logic [7:0]  BYTE_CR  = 8'd13;

   localparam logic [7:0]  DELIMITER_RESET = 8'd44;
   localparam logic [7:0]  QUOTE_RESET     = 8'd34;

   localparam logic        CMD_DATA = 1'b0;
   localparam logic        CMD_END  = 1'b1;

   localparam logic        CSR_DELIMITER = 1'b0;
   localparam logic        CSR_QUOTE     = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NUL      = 2'd1,
      ERR_JUNK     = 2'd2,
      ERR_UNCLOSED = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      M_START  = 3'd0,
      M_NEXT   = 3'd1,
      M_QUOTED = 3'd2,
      M_PLAIN  = 3'd3,
      M_AFTERQ = 3'd4,
      M_QSEEN  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LINE,
      ACT_DATA,
      ACT_FIELD,
      ACT_ROW,
      ACT_ROW_FIELD,
      ACT_ERROR,
      ACT_CLEAR
   } act_type;

   typedef struct packed {
      logic        data_valid;
      logic [7:0]  data_byte;
      logic        field_end;
      logic        row_end;
      logic [7:0]  field_count;
      logic [15:0] lines_in_row;
      logic [1:0]  error_code;
   } rsp_item_type;

endpackage

FILE: hdl/cfs_req_if.sv
// cfs_req_if: input byte channel of the csv field splitter
// valid/ready handshake; no package dependency
`timescale 1ns / 1ps

interface cfs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] in_byte;

   modport source (output valid, output command, output in_byte, input ready);
   modport sink   (input valid, input command, input in_byte, output ready);
endinterface

FILE: hdl/cfs_rsp_if.sv
// cfs_rsp_if: result channel of the csv field splitter
// valid/ready handshake; no package dependency
`timescale 1ns / 1ps

interface cfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        data_valid;
   logic [7:0]  data_byte;
   logic        field_end;
   logic        row_end;
   logic [7:0]  field_count;
   logic [15:0] lines_in_row;
   logic [1:0]  error_code;

   modport source (output valid, output data_valid, output data_byte, output field_end,
                   output row_end, output field_count, output lines_in_row,
                   output error_code, input ready);
   modport sink   (input valid, input data_valid, input data_byte, input field_end,
                   input row_end, input field_count, input lines_in_row,
                   input error_code, output ready);
endinterface

FILE: hdl/csv_field_splitter.sv
// csv_field_splitter: streaming csv splitter, top level
// depends on cfs_pkg, cfs_req_if and cfs_rsp_if
`timescale 1ns / 1ps

// Takes one byte (or an end-of-input mark) per clock while req.ready is high, and
// gives at most one result per transaction: a field byte, a field end, a row end or
// an error. Throughput is one transaction per cycle while req.ready is high; the parse
// state updates when a byte is taken, and the result is registered into the output
// register, or into the one-entry skid buffer behind it when the output register holds
// a result the sink has not taken, so req.ready drops only when both hold an untaken
// result. Delimiter and quote registers should be written only while the block is idle.
module csv_field_splitter
   import cfs_pkg::*;
#(
   parameter int     FIELD_COUNT_MAX = FIELD_COUNT_MAX_DEF,
   parameter longint LINE_COUNT_MAX  = LINE_COUNT_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   cfs_req_if.sink    req,
   cfs_rsp_if.source  rsp
);

   localparam int FW = $clog2(FIELD_COUNT_MAX + 1);
   localparam int LW = $clog2(LINE_COUNT_MAX + 1);
   localparam logic [FW-1:0] FMAX = FW'(FIELD_COUNT_MAX);
   localparam logic [LW-1:0] LMAX = LW'(LINE_COUNT_MAX);

   logic [7:0]    delim_ff, quote_ff;
   mode_type      mode_ff, mode_in;
   logic [FW-1:0] fd_ff, fd_in, fd_sat;
   logic [LW-1:0] ls_ff, ls_in, ls_sat;
   logic          lo_ff, lo_in;

   rsp_item_type  out_ff, skid_ff, res;
   logic          out_valid_ff, skid_valid_ff;
   logic          out_valid_in, skid_valid_in;
   rsp_item_type  out_in, skid_in;

   act_type       act;
   err_type       err;
   logic          accept, pop, push;
   logic          is_end, is_lf, is_cr, is_nul, is_q, is_d;
   logic [FW+7:0] fc_new_wide, fc_old_wide;
   logic [LW+15:0] ln_wide;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIMITER_RESET;
         quote_ff <= QUOTE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELIMITER: delim_ff <= csr_wdata;
            CSR_QUOTE:     quote_ff <= csr_wdata;
         endcase
      end
   end

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;

   assign is_end = (req.command == CMD_END);
   assign is_lf  = (req.in_byte == BYTE_LF);
   assign is_cr  = (req.in_byte == BYTE_CR);
   assign is_nul = (req.in_byte == BYTE_NUL);
   assign is_q   = (req.in_byte == quote_ff);
   assign is_d   = (req.in_byte == delim_ff);

   assign fd_sat = (fd_ff < FMAX) ? fd_ff + 1'b1 : fd_ff;
   assign ls_sat = (ls_ff < LMAX) ? ls_ff + 1'b1 : ls_ff;

   // next state: parse mode and the action for this byte
   always_comb begin
      mode_in = mode_ff;
      act     = ACT_NONE;
      err     = ERR_NONE;
      if (is_end) begin
         unique case (mode_ff)
            M_QUOTED: begin
               act = ACT_ERROR;
               err = ERR_UNCLOSED;
            end
            M_START:  act = (!lo_ff && ls_ff == '0) ? ACT_CLEAR : ACT_ROW;
            M_AFTERQ: act = ACT_ROW;
            default:  act = ACT_ROW_FIELD;
         endcase
      end else if (is_lf) begin
         if (mode_ff == M_QUOTED) act = ACT_LINE;
         else if (mode_ff == M_START || mode_ff == M_AFTERQ) act = ACT_ROW;
         else act = ACT_ROW_FIELD;
      end else if (is_cr) begin
         if (mode_ff == M_QSEEN) begin
            mode_in = M_AFTERQ;
            act     = ACT_FIELD;
         end
      end else if (is_nul) begin
         act = ACT_ERROR;
         err = ERR_NUL;
      end else begin
         unique case (mode_ff)
            M_START, M_NEXT: begin
               if (is_q) mode_in = M_QUOTED;
               else if (is_d) begin
                  mode_in = M_NEXT;
                  act     = ACT_FIELD;
               end else begin
                  mode_in = M_PLAIN;
                  act     = ACT_DATA;
               end
            end
            M_QUOTED: begin
               if (is_q) mode_in = M_QSEEN;
               else act = ACT_DATA;
            end
            M_QSEEN: begin
               if (is_q) begin
                  mode_in = M_QUOTED;
                  act     = ACT_DATA;
               end else if (is_d) begin
                  mode_in = M_NEXT;
                  act     = ACT_FIELD;
               end else begin
                  act = ACT_ERROR;
                  err = ERR_JUNK;
               end
            end
            M_PLAIN: begin
               if (is_d) begin
                  mode_in = M_NEXT;
                  act     = ACT_FIELD;
               end else act = ACT_DATA;
            end
            M_AFTERQ: begin
               if (is_d) mode_in = M_NEXT;
               else begin
                  act = ACT_ERROR;
                  err = ERR_JUNK;
               end
            end
            default: act = ACT_CLEAR;
         endcase
      end
      if (act == ACT_ROW || act == ACT_ROW_FIELD || act == ACT_ERROR || act == ACT_CLEAR)
         mode_in = M_START;
   end

   assign fc_new_wide = {8'b0, fd_sat};
   assign fc_old_wide = {8'b0, fd_ff};
   assign ln_wide     = {16'b0, ls_sat};

   // counters and result
   always_comb begin
      fd_in = fd_ff;
      ls_in = ls_ff;
      lo_in = lo_ff | (!is_end && !is_lf);
      res   = '0;
      push  = 1'b0;
      case (act)
         ACT_LINE: ls_in = ls_sat;
         ACT_DATA: begin
            push           = 1'b1;
            res.data_valid = 1'b1;
            res.data_byte  = req.in_byte;
            res.field_count = fc_old_wide[7:0];
         end
         ACT_FIELD: begin
            fd_in           = fd_sat;
            push            = 1'b1;
            res.field_end   = 1'b1;
            res.field_count = fc_new_wide[7:0];
         end
         ACT_ROW: begin
            push             = 1'b1;
            res.row_end      = 1'b1;
            res.field_count  = fc_old_wide[7:0];
            res.lines_in_row = ln_wide[15:0];
         end
         ACT_ROW_FIELD: begin
            push             = 1'b1;
            res.field_end    = 1'b1;
            res.row_end      = 1'b1;
            res.field_count  = fc_new_wide[7:0];
            res.lines_in_row = ln_wide[15:0];
         end
         ACT_ERROR: begin
            push           = 1'b1;
            res.error_code = err;
         end
         default: ;
      endcase
      if (act == ACT_ROW || act == ACT_ROW_FIELD || act == ACT_ERROR || act == ACT_CLEAR) begin
         fd_in = '0;
         ls_in = '0;
         lo_in = 1'b0;
      end
      push = push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_START;
         fd_ff   <= '0;
         ls_ff   <= '0;
         lo_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         fd_ff   <= fd_in;
         ls_ff   <= ls_in;
         lo_ff   <= lo_in;
      end
   end

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_in       = res;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.data_valid   = out_ff.data_valid;
   assign rsp.data_byte    = out_ff.data_byte;
   assign rsp.field_end    = out_ff.field_end;
   assign rsp.row_end      = out_ff.row_end;
   assign rsp.field_count  = out_ff.field_count;
   assign rsp.lines_in_row = out_ff.lines_in_row;
   assign rsp.error_code   = out_ff.error_code;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && act == ACT_ERROR) |=> (mode_ff == M_START && fd_ff == '0 && ls_ff == '0))
      else $error("parser not cleared after error");

   a_field_sat: assert property (@(posedge clock) disable iff (reset)
      fd_ff <= FMAX)
      else $error("field count above its limit");

   a_error_result_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.error_code != ERR_NONE) |->
         (!out_ff.data_valid && !out_ff.field_end && !out_ff.row_end
          && out_ff.field_count == 8'd0))
      else $error("error result carries field data");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !pop) |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost while stalled");

endmodule
